/* hdl/dsi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsi_pkg: shared types and constants of the decimal string parser
// Character codes, the magnitude limit and the per-string parse state.
// ----------------------------------------------------------------------------
package dsi_pkg;

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// magnitude width and its largest legal value (2^63, negatives only)
	localparam int unsigned MAG_W = 64;
	localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};

	// position within the current string
	typedef enum logic [1:0] {
		PH_START       = 2'd0,
		PH_AFTER_MINUS = 2'd1,
		PH_DIGITS      = 2'd2
	} phase_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		phase_t           phase;
		logic             is_negative;
		logic             failed;
		logic             lone_zero;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		magnitude:   '0,
		phase:       PH_START,
		is_negative: 1'b0,
		failed:      1'b0,
		lone_zero:   1'b0
	};

	// one finished result
	typedef struct packed {
		logic             parse_ok;
		logic [MAG_W-1:0] parsed_value;
	} parse_result_t;

endpackage : dsi_pkg
`default_nettype wire

/* hdl/dsi_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsi_step: one character step of the parser
// Decodes a character against the current state, accumulates magnitude*10+d
// with its overflow check, and forms the result at the end of a string.
// ----------------------------------------------------------------------------
module dsi_step (
	input  dsi_pkg::parse_state_t  cur,
	input  logic [7:0]             char_byte,
	input  logic                   last_byte,
	input  logic                   string_empty,
	output dsi_pkg::parse_state_t  nxt,
	output logic                   emit,
	output dsi_pkg::parse_result_t result
);
	import dsi_pkg::*;

	logic             is_digit;
	logic             is_nonzero;
	logic [3:0]       digit;
	logic [MAG_W+3:0] acc;
	logic             acc_over;
	parse_state_t     st;
	logic             ok;
	logic [MAG_W-1:0] val;

	// character classes
	assign is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
	assign is_nonzero = (char_byte >= CH_ONE) && (char_byte <= CH_NINE);
	assign digit      = char_byte[3:0];

	// magnitude*10 + digit as shift-add; magnitude never exceeds 2^63, so
	// 68 bits hold the sum and one compare covers both overflow checks
	assign acc = {1'b0, cur.magnitude, 3'b000} + {3'b000, cur.magnitude, 1'b0}
		+ {{MAG_W{1'b0}}, digit};
	assign acc_over = acc > {4'b0000, MAG_LIMIT};

	// state update for this character
	always_comb begin
		st = cur;
		if (!cur.failed) begin
			case (cur.phase)
				PH_START: begin
					if (char_byte == CH_MINUS) begin
						st.is_negative = 1'b1;
						st.phase       = PH_AFTER_MINUS;
					end else if (is_nonzero) begin
						st.magnitude = {{(MAG_W-4){1'b0}}, digit};
						st.phase     = PH_DIGITS;
					end else if (char_byte == CH_ZERO && last_byte) begin
						st.lone_zero = 1'b1;
					end else begin
						st.failed = 1'b1;
					end
				end
				PH_AFTER_MINUS: begin
					if (is_nonzero) begin
						st.magnitude = {{(MAG_W-4){1'b0}}, digit};
						st.phase     = PH_DIGITS;
					end else begin
						st.failed = 1'b1;
					end
				end
				default: begin
					if (!is_digit || acc_over) begin
						st.failed = 1'b1;
					end else begin
						st.magnitude = acc[MAG_W-1:0];
					end
				end
			endcase
		end
	end

	// end-of-string verdict
	always_comb begin
		ok  = 1'b0;
		val = '0;
		if (string_empty || st.failed) begin
			ok = 1'b0;
		end else if (st.lone_zero) begin
			ok = 1'b1;
		end else if (st.phase != PH_DIGITS) begin
			ok = 1'b0;
		end else if (st.is_negative) begin
			ok  = st.magnitude <= MAG_LIMIT;
			val = '0 - st.magnitude;
		end else begin
			ok  = st.magnitude < MAG_LIMIT;
			val = st.magnitude;
		end
	end

	assign emit                = string_empty || last_byte;
	assign nxt                 = emit ? STATE_RESET : st;
	assign result.parse_ok     = ok;
	assign result.parsed_value = ok ? val : '0;

endmodule : dsi_step
`default_nettype wire

/* hdl/decimal_string_to_int64.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_string_to_int64: strict ASCII decimal to signed 64-bit parser
// Input register, one character step, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one ASCII character per item. s_tlast marks the final
//   character of a string; s_tuser = 1 stands for an empty string.
//   Master channel m_*: one item per string, m_tuser = parse_ok and
//   m_tdata = two's complement value (zero when the parse failed).
//   Throughput: one character per cycle unless a final character waits for a
//   busy result register. The accumulate step (shift-add of magnitude*10 +
//   digit with its overflow compare) sits between the input register and the
//   result register. A string's final character passes the input register,
//   then the result register, before its result is valid on m_*.
//   Stall: characters that end no string keep flowing while a result waits;
//   a final character holds in the input register until the result
//   register is free, and s_tready is low only while such a character waits.
//   Reset: arst_n clears the input and result valid flags and returns the
//   parser to the start of a string.
// ----------------------------------------------------------------------------
module decimal_string_to_int64 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
	input  wire logic        s_tlast,   // last_byte
	input  wire logic        s_tuser,   // [0] string_empty
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [63:0] parsed_value
	output logic             m_tuser    // [0] parse_ok
);
	import dsi_pkg::*;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;
	logic          empty_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	logic          emit;
	parse_result_t result;
	logic          out_valid_q;
	parse_result_t out_q;
	logic          adv_s1;

	// character step on the registered item
	dsi_step u_step (
		.cur          (state_q),
		.char_byte    (char_s1),
		.last_byte    (last_s1),
		.string_empty (empty_s1),
		.nxt          (state_nxt),
		.emit         (emit),
		.result       (result)
	);

	// the registered item moves on unless its result has nowhere to go
	assign adv_s1   = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1  <= s_tdata;
			last_s1  <= s_tlast;
			empty_s1 <= s_tuser;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.parsed_value;
	assign m_tuser  = out_q.parse_ok;

endmodule : decimal_string_to_int64
`default_nettype wire

/* tb/tb_decimal_string_to_int64.sv */
// ----------------------------------------------------------------------------
// tb_decimal_string_to_int64: self-checking bench of the decimal string parser
// Streams ASCII strings into the parser, one character per item, and checks
// each parse result against a cycle-free model of the strict decimal rules.
// The stimulus starts with hand-picked strings and continues with random
// numbers, int64 boundary values, zero forms, empty strings and noise.
// Both stream sides idle at random, and the output side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_decimal_string_to_int64;
	import dsi_pkg::*;

	localparam int TARGET_ITEMS  = 450;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AFTER    = 40;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LIMIT_CYCLES  = 200000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       empty;
	} char_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;

	char_item_t    char_q[$];     // characters still to be sent
	parse_result_t parsed_q[$];   // parse results still awaited
	parse_state_t  str_st;        // model state of the current string
	char_item_t    cur_item;
	int            n_stim = 0;
	int            n_sent = 0;
	int            n_err = 0;
	logic [1:0]    idle_phase = 2'd0;

	decimal_string_to_int64 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] char_byte
		.s_tlast  (s_tlast),   // last_byte
		.s_tuser  (s_tuser),   // [0] string_empty
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [63:0] parsed_value
		.m_tuser  (m_tuser)    // [0] parse_ok
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Model of one character step; emits is set when the item ends a string
	task automatic parse_char(input char_item_t it, output bit emits,
			output parse_result_t res);
		logic [67:0] wide;
		logic        ok;
		logic [63:0] val;
		emits = 1'b0;
		res   = '0;
		ok    = 1'b0;
		val   = '0;
		if (it.empty) begin
			emits  = 1'b1;
			str_st = STATE_RESET;
		end else begin
			if (!str_st.failed) begin
				case (str_st.phase)
					PH_START: begin
						if (it.ch == CH_MINUS) begin
							str_st.is_negative = 1'b1;
							str_st.phase = PH_AFTER_MINUS;
						end else if (it.ch >= CH_ONE && it.ch <= CH_NINE) begin
							str_st.magnitude = 64'(it.ch - CH_ZERO);
							str_st.phase = PH_DIGITS;
						end else if (it.ch == CH_ZERO && it.last) begin
							str_st.lone_zero = 1'b1;
						end else begin
							str_st.failed = 1'b1;
						end
					end
					PH_AFTER_MINUS: begin
						if (it.ch >= CH_ONE && it.ch <= CH_NINE) begin
							str_st.magnitude = 64'(it.ch - CH_ZERO);
							str_st.phase = PH_DIGITS;
						end else begin
							str_st.failed = 1'b1;
						end
					end
					default: begin
						if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
							// magnitude stays <= 2^63, so 68 bits never wrap
							wide = 68'(str_st.magnitude) * 68'd10 + 68'(it.ch - CH_ZERO);
							if (wide > 68'(MAG_LIMIT))
								str_st.failed = 1'b1;
							else
								str_st.magnitude = wide[63:0];
						end else begin
							str_st.failed = 1'b1;
						end
					end
				endcase
			end
			if (it.last) begin
				emits = 1'b1;
				if (str_st.failed) begin
					ok = 1'b0;
				end else if (str_st.lone_zero) begin
					ok = 1'b1;
				end else if (str_st.phase != PH_DIGITS) begin
					ok = 1'b0;
				end else if (str_st.is_negative) begin
					ok  = str_st.magnitude <= MAG_LIMIT;
					val = -str_st.magnitude;
				end else begin
					ok  = str_st.magnitude < MAG_LIMIT;
					val = str_st.magnitude;
				end
				res.parse_ok     = ok;
				res.parsed_value = ok ? val : '0;
				str_st = STATE_RESET;
			end
		end
	endtask

	// Stimulus helpers
	task automatic push_char(input logic [7:0] c, input logic last);
		char_q.push_back('{ch: c, last: last, empty: 1'b0});
	endtask

	task automatic push_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], close && (i == s.len() - 1));
	endtask

	task automatic push_empty(input logic [7:0] c, input logic last);
		char_q.push_back('{ch: c, last: last, empty: 1'b1});
	endtask

	task automatic push_seq(input logic [7:0] txt[$]);
		for (int i = 0; i < txt.size(); i++)
			push_char(txt[i], i == txt.size() - 1);
	endtask

	// Well-formed number text: optional minus, nonzero lead digit, more digits
	task automatic make_number(input bit neg, input int ndig, output logic [7:0] txt[$]);
		txt = {};
		if (neg)
			txt.push_back(CH_MINUS);
		txt.push_back(CH_ONE + 8'($urandom_range(0, 8)));
		for (int i = 1; i < ndig; i++)
			txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic build_stimulus();
		logic [7:0] txt[$];
		int         pick;
		int         pos;
		// hand-picked strings
		push_text("0", 1);
		push_text("-", 1);
		push_text("-0", 1);
		push_text("01", 1);
		push_text("+5", 1);
		push_text("-7", 1);
		push_text("5a", 1);
		push_text("9", 1);
		push_char(8'hFF, 1'b1);
		push_char(8'h00, 1'b1);
		push_empty(8'hA5, 1'b0);
		push_text("12", 0);
		push_empty(8'h5A, 1'b1);
		push_text(" 3", 1);
		// random strings
		while (char_q.size() < TARGET_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				make_number(1'($urandom_range(0, 1)), int'($urandom_range(1, 20)), txt);
				push_seq(txt);
			end else if (pick < 55) begin
				// around the int64 limits: 922337203685477580x, sometimes longer
				if ($urandom_range(0, 1))
					push_char(CH_MINUS, 1'b0);
				push_text("922337203685477580", 0);
				if ($urandom_range(0, 3) == 0) begin
					push_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
					push_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
				end else begin
					push_char(CH_ZERO + 8'($urandom_range(6, 9)), 1'b1);
				end
			end else if (pick < 63) begin
				// zero forms, with and without sign and trailing digits
				if ($urandom_range(0, 1))
					push_char(CH_MINUS, 1'b0);
				if ($urandom_range(0, 1)) begin
					push_char(CH_ZERO, 1'b1);
				end else begin
					push_char(CH_ZERO, 1'b0);
					push_text("47", 1);
				end
			end else if (pick < 73) begin
				// empty marker, sometimes cutting a string short
				repeat ($urandom_range(0, 3))
					push_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
				push_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (pick < 86) begin
				// number with one character replaced by any byte
				make_number(1'($urandom_range(0, 1)), int'($urandom_range(1, 8)), txt);
				pos = int'($urandom_range(0, txt.size() - 1));
				txt[pos] = 8'($urandom_range(0, 255));
				push_seq(txt);
			end else begin
				// pure noise
				txt = {};
				repeat ($urandom_range(1, 6))
					txt.push_back(8'($urandom_range(0, 255)));
				push_seq(txt);
			end
		end
		n_stim = char_q.size();
	endtask

	function automatic int tx_idle_pct(input logic [1:0] ph);
		case (ph)
			2'd0:    return 15;
			2'd1:    return 49;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct(input logic [1:0] ph);
		case (ph)
			2'd0:    return 49;
			2'd1:    return 15;
			default: return 0;
		endcase
	endfunction

	// Driver: offers characters from the queue and predicts at acceptance
	always @(posedge clk) begin
		bit            emits;
		parse_result_t res;
		bit            offering;
		if (arst_n) begin
			offering = s_tvalid;
			if (s_tvalid && s_tready) begin
				parse_char(cur_item, emits, res);
				if (emits)
					parsed_q.push_back(res);
				n_sent++;
				offering = 1'b0;
				idle_phase <= (n_sent >= 2 * n_stim / 3) ? 2'd2 :
					(n_sent >= n_stim / 3) ? 2'd1 : 2'd0;
			end
			if (!offering) begin
				if (char_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct(idle_phase)) begin
					cur_item = char_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_item.ch;
					s_tlast  <= cur_item.last;
					s_tuser  <= cur_item.empty;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		int n_taken;
		int hold_left;
		bit hold_done;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				n_taken++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && n_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(0, 99) >= rx_idle_pct(idle_phase);
			end
		end
	end

	// Monitor: compare each parse result with the oldest prediction
	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (parsed_q.size() == 0) begin
				$error("unexpected result: parse_ok=%0b parsed_value=%0d",
					m_tuser, $signed(m_tdata));
				n_err++;
			end else begin
				want = parsed_q.pop_front();
				if (m_tuser !== want.parse_ok) begin
					$error("parse_ok: expected %0b, got %0b", want.parse_ok, m_tuser);
					n_err++;
				end
				if (m_tdata !== want.parsed_value) begin
					$error("parsed_value: expected %0d, got %0d",
						$signed(want.parsed_value), $signed(m_tdata));
					n_err++;
				end
			end
		end
	end

	// Sequence: reset, stream everything, drain, report
	initial begin
		str_st = STATE_RESET;
		build_stimulus();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (char_q.size() > 0 || s_tvalid || parsed_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_err == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_CYCLES * 20);
		$display("tb: failure");
		$finish;
	end

endmodule
